// ----- rtl/core/cst_pkg.sv -----
// Shared types and constants for the counting semaphore table.
package cst_pkg;
   localparam int SEM_SLOTS_DEF  = 64;
   localparam int PROCESSES_DEF  = 32;
   localparam int COUNT_BITS_DEF = 15;
   localparam int MAX_RESULTS    = 32;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_P      = 2'd1;
   localparam logic [1:0] OP_V      = 2'd2;
   localparam logic [1:0] OP_FREE   = 2'd3;

   localparam logic [2:0] ST_DONE       = 3'd0;
   localparam logic [2:0] ST_BLOCKED    = 3'd1;
   localparam logic [2:0] ST_BAD_HANDLE = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_BAD_VALUE  = 3'd4;

   // request as queued by the front end
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  sem_handle;
      logic [15:0] init_count;
      logic [4:0]  requester;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] result_handle;
      logic       wake_valid;
      logic [4:0] wake_process;
      logic       wake_cause;
      logic       last;
   } rsp_type;
endpackage

// ----- rtl/core/cst_front.sv -----
// Front end: accepts requests into a two-entry queue toward the back end.
module cst_front import cst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_req,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_req
);
   req_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_req   = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= in_req;
   end
endmodule

// ----- rtl/core/cst_back.sv -----
// Back end: semaphore state, wait queues and the result register.
module cst_back import cst_pkg::*; #(
   parameter int SEM_SLOTS  = SEM_SLOTS_DEF,
   parameter int PROCESSES  = PROCESSES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_req,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);
   localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_WALK} state_type;

   logic [SEM_SLOTS-1:0]  used_ff, nonempty_ff;
   logic [COUNT_BITS-1:0] count_mem [SEM_SLOTS];
   logic [4:0]            head_mem  [SEM_SLOTS];
   logic [4:0]            tail_mem  [SEM_SLOTS];
   logic [4:0]            next_mem  [PROCESSES];

   state_type       state_ff;
   req_type         r_ff;
   logic [SW-1:0]   slot_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [4:0]      head_rd_ff, tail_rd_ff, next_rd_ff, tail_w_ff;
   logic [4:0]      k_ff;
   logic            ov_ff;
   rsp_type         rsp_ff, exec_rsp;
   logic            hvalid, free_found, exec_walk, walk_emit, walk_last;
   logic [SW-1:0]   free_slot;
   logic [COUNT_BITS-1:0] iv_sat;

   assign in_ready  = (state_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_rsp   = rsp_ff;
   assign hvalid    = ({8'd0, in_req.sem_handle} < 16'(SEM_SLOTS));
   // V and free with more than one waiter need the walk state
   assign exec_walk = ((r_ff.op == OP_V) || (r_ff.op == OP_FREE)) && nonempty_ff[slot_ff]
                      && (head_rd_ff != tail_rd_ff);
   assign walk_emit = (state_ff == S_WALK) && (r_ff.op != OP_V) && (!ov_ff || out_ready);
   assign walk_last = (next_rd_ff == tail_w_ff) || (k_ff == 5'(MAX_RESULTS - 1));

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
      if ({17'd0, r_ff.init_count[14:0]} > 32'(CMAX)) iv_sat = CMAX;
      else iv_sat = COUNT_BITS'(r_ff.init_count[14:0]);
   end

   // first result of a request leaving the execute state
   always_comb begin
      exec_rsp = '{ST_DONE, r_ff.sem_handle[5:0], 1'b0, 5'd0, 1'b0, 1'b1};
      case (r_ff.op)
         OP_CREATE: begin
            if (r_ff.init_count[15]) begin
               exec_rsp.status        = ST_BAD_VALUE;
               exec_rsp.result_handle = 6'd0;
            end else if (!free_found) begin
               exec_rsp.status        = ST_FULL;
               exec_rsp.result_handle = 6'd0;
            end else begin
               exec_rsp.result_handle = 6'(free_slot);
            end
         end
         OP_P: begin
            if (cnt_rd_ff == '0) begin
               if ({3'd0, r_ff.requester} >= 8'(PROCESSES)) exec_rsp.status = ST_BAD_HANDLE;
               else exec_rsp.status = ST_BLOCKED;
            end
         end
         OP_V: begin
            if (nonempty_ff[slot_ff]) begin
               exec_rsp.wake_valid   = 1'b1;
               exec_rsp.wake_process = head_rd_ff;
            end
         end
         default: begin
            if (nonempty_ff[slot_ff]) begin
               exec_rsp.wake_valid   = 1'b1;
               exec_rsp.wake_process = head_rd_ff;
               exec_rsp.wake_cause   = 1'b1;
               exec_rsp.last         = (head_rd_ff == tail_rd_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ov_ff       <= 1'b0;
         used_ff     <= '0;
         nonempty_ff <= '0;
      end else begin
         if (out_valid && out_ready && !walk_emit) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid && in_ready) begin
                  r_ff    <= in_req;
                  slot_ff <= in_req.sem_handle[SW-1:0];
                  if (in_req.op == OP_CREATE) begin
                     state_ff <= S_EXEC;
                  end else if (!hvalid || !used_ff[in_req.sem_handle[SW-1:0]]) begin
                     rsp_ff <= '{ST_BAD_HANDLE, in_req.sem_handle[5:0], 1'b0, 5'd0,
                                 1'b0, 1'b1};
                     ov_ff  <= 1'b1;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               cnt_rd_ff  <= count_mem[slot_ff];
               head_rd_ff <= head_mem[slot_ff];
               tail_rd_ff <= tail_mem[slot_ff];
               state_ff   <= S_EXEC;
            end
            S_EXEC: begin
               next_rd_ff <= next_mem[PW'(head_rd_ff)];
               tail_w_ff  <= tail_rd_ff;
               k_ff       <= 5'd1;
               state_ff   <= exec_walk ? S_WALK : S_IDLE;
               ov_ff      <= 1'b1;
               rsp_ff     <= exec_rsp;
               case (r_ff.op)
                  OP_CREATE: begin
                     if (!r_ff.init_count[15] && free_found) begin
                        used_ff[free_slot]     <= 1'b1;
                        nonempty_ff[free_slot] <= 1'b0;
                        count_mem[free_slot]   <= iv_sat;
                     end
                  end
                  OP_P: begin
                     if (cnt_rd_ff != '0) begin
                        count_mem[slot_ff] <= cnt_rd_ff - COUNT_BITS'(1);
                     end else if ({3'd0, r_ff.requester} < 8'(PROCESSES)) begin
                        if (nonempty_ff[slot_ff]) next_mem[PW'(tail_rd_ff)] <= r_ff.requester;
                        else head_mem[slot_ff] <= r_ff.requester;
                        nonempty_ff[slot_ff] <= 1'b1;
                        tail_mem[slot_ff]    <= r_ff.requester;
                     end
                  end
                  OP_V: begin
                     // pop the head; the new head is written in the walk state
                     if (nonempty_ff[slot_ff]) begin
                        if (head_rd_ff == tail_rd_ff) nonempty_ff[slot_ff] <= 1'b0;
                     end else if (cnt_rd_ff != CMAX) begin
                        count_mem[slot_ff] <= cnt_rd_ff + COUNT_BITS'(1);
                     end
                  end
                  default: begin
                     used_ff[slot_ff]     <= 1'b0;
                     nonempty_ff[slot_ff] <= 1'b0;
                  end
               endcase
            end
            S_WALK: begin
               if (r_ff.op == OP_V) begin
                  head_mem[slot_ff] <= next_rd_ff;
                  state_ff          <= S_IDLE;
               end else if (walk_emit) begin
                  // emit next waiter of the freed queue
                  ov_ff      <= 1'b1;
                  rsp_ff     <= '{ST_DONE, r_ff.sem_handle[5:0], 1'b1, next_rd_ff, 1'b1,
                                  walk_last};
                  next_rd_ff <= next_mem[PW'(next_rd_ff)];
                  k_ff       <= k_ff + 5'd1;
                  if (walk_last) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/core/counting_semaphore_table.sv -----
// Counting semaphore table with per-slot FIFO wait queues, top level.
// The back end takes a new request only when idle with no result pending,
// while the front end queues up to two more. Requests pass through read and
// execute states (create skips the read; a bad handle is answered from the
// idle state); V and free with more than one waiter then walk the queue, and
// free returns one result per released waiter, at most 32, the last by tlast.
// Synchronous reset clears slot-in-use and queue flags at once; no clearing pass.
module counting_semaphore_table import cst_pkg::*; #(
   parameter int SEM_SLOTS  = SEM_SLOTS_DEF,
   parameter int PROCESSES  = PROCESSES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // op, sem_handle, init_count, requester
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // status, result_handle, wake_valid, wake_process,
                                   // wake_cause
   output logic        rsp_tlast
);
   req_type q_in, q_out;
   rsp_type r;
   logic    q_valid, q_ready;

   assign q_in = '{req_tdata[1:0], req_tdata[9:2], req_tdata[25:10], req_tdata[30:26]};

   cst_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_req(q_in),
      .out_valid(q_valid), .out_ready(q_ready), .out_req(q_out)
   );

   cst_back #(.SEM_SLOTS(SEM_SLOTS), .PROCESSES(PROCESSES), .COUNT_BITS(COUNT_BITS))
   u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_req(q_out),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(r)
   );

   assign rsp_tdata = {r.wake_cause, r.wake_process, r.wake_valid, r.result_handle, r.status};
   assign rsp_tlast = r.last;
endmodule
